[src/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies; each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ogsi_pkg.sv]
// shared types and constants for the occupancy grid square inflation block
// no dependencies
package ogsi_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_REACH  = 31;

  // configuration register indexes
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_REACH      = 2'd2;

  // configuration reset values
  localparam logic [8:0] MAP_WIDTH_RST  = 9'd256;
  localparam logic [8:0] MAP_HEIGHT_RST = 9'd256;
  localparam logic [4:0] REACH_RST      = 5'd7;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // occupancy thresholds and output cost
  localparam logic signed [7:0] OCC_LOW  = 8'sd50;
  localparam logic signed [7:0] OCC_HIGH = 8'sd100;
  localparam logic [6:0] COST_OCCUPIED   = 7'd100;
  localparam logic [6:0] COST_FREE       = 7'd0;

  // one input transfer
  typedef struct packed {
    logic              command;
    logic [7:0]        row;
    logic [7:0]        col;
    logic signed [7:0] cell_value;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic [6:0] inflated_value;
    logic       out_of_range;
  } out_t;

endpackage

[src/ogsi_row_mem.sv]
// one-port-write, one-port-read row memory with registered read data
// no dependencies
module ogsi_row_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/occupancy_grid_square_inflation.sv]
// top level of the occupancy grid square inflation block
// depends on ogsi_pkg and ogsi_row_mem
//
//  channel | ports                             | transfer when
//  --------+-----------------------------------+---------------------------
//  input   | start, busy, in_data              | start high, busy low
//  result  | out_valid, out_data               | out_valid high (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_index,  | cfg_valid and cfg_ready
//          | cfg_data                          |
//
// the map is held as one row word per map row; a load is a read-modify-write
// of its row: the row word is read on acceptance and written back in S_LD_WB.
// a query reads one row word per cycle over the clamped window rows. a query
// outside the map or with reach zero answers in the cycle after it is
// accepted. the memory is not cleared after reset. results cannot be stalled
// and busy drops as the result strobe is shown.
module occupancy_grid_square_inflation #(
  parameter int MAX_WIDTH  = ogsi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ogsi_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_REACH  = ogsi_pkg::DEF_MAX_REACH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ogsi_pkg::in_t   in_data,
  output logic            out_valid,
  output ogsi_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [8:0]      cfg_data
);

  localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WB,
    S_Q_MASK,
    S_Q_RUN,
    S_Q_END
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  ogsi_pkg::out_t         out_data_r;
  ogsi_pkg::in_t          req_r;
  logic [8:0]             map_width_r;
  logic [8:0]             map_height_r;
  logic [4:0]             reach_r;
  logic [9:0]             r0_r;
  logic [9:0]             r1_r;
  logic [9:0]             c0_r;
  logic [9:0]             c1_r;
  logic [9:0]             cur_row_r;
  logic [MAX_WIDTH-1:0]   mask_r;
  logic                   rd_vld_r;
  logic                   hit_r;

  logic                   accept;
  logic [8:0]             eff_w;
  logic [8:0]             eff_h;
  logic [4:0]             eff_k;
  logic                   inside_w;
  logic [9:0]             r0_w;
  logic [9:0]             r1_w;
  logic [9:0]             c0_w;
  logic [9:0]             c1_w;
  logic [9:0]             row_up;
  logic [9:0]             col_up;
  logic [9:0]             row_far;
  logic [9:0]             col_far;
  logic [9:0]             row_lim;
  logic [9:0]             col_lim;
  logic [MAX_WIDTH-1:0]   mask_w;
  logic                   row_hit_w;
  logic                   occ_w;

  logic                   mem_we;
  logic [RAW-1:0]         mem_waddr;
  logic [MAX_WIDTH-1:0]   mem_wdata;
  logic                   mem_re;
  logic [RAW-1:0]         mem_raddr;
  logic [MAX_WIDTH-1:0]   mem_rdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective map size and reach after saturation
  always_comb begin
    eff_w = (int'(map_width_r) > MAX_WIDTH) ? 9'(MAX_WIDTH) : map_width_r;
    eff_h = (int'(map_height_r) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : map_height_r;
    eff_k = (int'(reach_r) > MAX_REACH) ? 5'(MAX_REACH) : reach_r;
  end

  // window bounds clamped to the map
  always_comb begin
    inside_w = ({1'b0, in_data.row} < eff_h) && ({1'b0, in_data.col} < eff_w);
    row_up   = {2'b0, in_data.row} + 10'd1;
    col_up   = {2'b0, in_data.col} + 10'd1;
    r0_w     = (row_up >= {5'b0, eff_k}) ? (row_up - {5'b0, eff_k}) : 10'd0;
    c0_w     = (col_up >= {5'b0, eff_k}) ? (col_up - {5'b0, eff_k}) : 10'd0;
    row_far  = {2'b0, in_data.row} + {5'b0, eff_k};
    col_far  = {2'b0, in_data.col} + {5'b0, eff_k};
    row_lim  = {1'b0, eff_h} - 10'd1;
    col_lim  = {1'b0, eff_w} - 10'd1;
    r1_w     = (row_far > row_lim) ? row_lim : row_far;
    c1_w     = (col_far > col_lim) ? col_lim : col_far;
  end

  // column mask of the window
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask_w[i] = (i >= int'(c0_r)) && (i <= int'(c1_r));
    end
  end

  // hit in the row word returned this cycle
  assign row_hit_w = rd_vld_r && (|(mem_rdata & mask_r));

  // occupancy of the loaded value
  assign occ_w = (req_r.cell_value >= ogsi_pkg::OCC_LOW) &&
                 (req_r.cell_value <= ogsi_pkg::OCC_HIGH);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = RAW'(cur_row_r);
    mem_we    = 1'b0;
    mem_waddr = RAW'(req_r.row);
    mem_wdata = mem_rdata;
    mem_wdata[CAW'(req_r.col)] = occ_w;
    case (state_r)
      S_IDLE: begin
        mem_re    = accept && (in_data.command == ogsi_pkg::CMD_LOAD) && inside_w;
        mem_raddr = RAW'(in_data.row);
      end
      S_LD_WB: begin
        mem_we = 1'b1;
      end
      S_Q_RUN: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // sequencer, configuration registers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      map_width_r  <= ogsi_pkg::MAP_WIDTH_RST;
      map_height_r <= ogsi_pkg::MAP_HEIGHT_RST;
      reach_r      <= ogsi_pkg::REACH_RST;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
    end else begin
      // result strobe: immediate answer or end of a window scan
      out_valid_r <= ((state_r == S_IDLE) && accept &&
                      (in_data.command == ogsi_pkg::CMD_QUERY) &&
                      (!inside_w || (eff_k == 5'd0))) ||
                     (state_r == S_Q_END);
      if (cfg_valid) begin
        case (cfg_index)
          ogsi_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_data;
          ogsi_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_data;
          ogsi_pkg::REG_REACH:      reach_r      <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r <= in_data;
            r0_r  <= r0_w;
            r1_r  <= r1_w;
            c0_r  <= c0_w;
            c1_r  <= c1_w;
            if (in_data.command == ogsi_pkg::CMD_LOAD) begin
              if (inside_w) begin
                state_r <= S_LD_WB;
              end
            end else if (!inside_w || (eff_k == 5'd0)) begin
              out_data_r.inflated_value <= ogsi_pkg::COST_FREE;
              out_data_r.out_of_range   <= !inside_w;
            end else begin
              state_r <= S_Q_MASK;
            end
          end
        end
        S_LD_WB: begin
          state_r <= S_IDLE;
        end
        S_Q_MASK: begin
          mask_r    <= mask_w;
          cur_row_r <= r0_r;
          hit_r     <= 1'b0;
          rd_vld_r  <= 1'b0;
          state_r   <= S_Q_RUN;
        end
        S_Q_RUN: begin
          hit_r    <= hit_r | row_hit_w;
          rd_vld_r <= 1'b1;
          if (cur_row_r == r1_r) begin
            state_r <= S_Q_END;
          end else begin
            cur_row_r <= cur_row_r + 10'd1;
          end
        end
        S_Q_END: begin
          out_data_r.inflated_value <= (hit_r | row_hit_w) ? ogsi_pkg::COST_OCCUPIED
                                                            : ogsi_pkg::COST_FREE;
          out_data_r.out_of_range   <= 1'b0;
          rd_vld_r                   <= 1'b0;
          state_r                    <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy bits, one row word per map row
  ogsi_row_mem #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH),
    .AW    (RAW)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[src/ogsi_checker.sv]
// port-level checks for the occupancy grid square inflation top level
// depends on ogsi_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module ogsi_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input ogsi_pkg::in_t  in_data,
  input logic           out_valid,
  input ogsi_pkg::out_t out_data
);

  // a result carries only free or occupied cost
  `ASSERT_IMPLY(a_cost_code, out_valid, (out_data.inflated_value == ogsi_pkg::COST_FREE) || (out_data.inflated_value == ogsi_pkg::COST_OCCUPIED), "result cost is neither free nor occupied")

  // an out-of-map result is always free
  `ASSERT_IMPLY(a_oor_free, out_valid && out_data.out_of_range, out_data.inflated_value == ogsi_pkg::COST_FREE, "out-of-map result marked occupied")

  // a load transfer never produces a result next cycle
  `ASSERT_NEXT(a_load_silent, start && !busy && (in_data.command == ogsi_pkg::CMD_LOAD), !out_valid, "load produced a result")

  // busy only rises after an accepted transfer
  `ASSERT_IMPLY(a_busy_cause, $rose(busy), $past(start), "busy rose without start")

endmodule

bind occupancy_grid_square_inflation ogsi_checker u_ogsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
